// ===== design/slc_pkg.sv =====
// ----------------------------------------------------------------------------
// slc_pkg
// Shared constants and codes for the size-budgeted LRU cache.
// ----------------------------------------------------------------------------
package slc_pkg;

  localparam int DEF_ENTRIES = 16;
  localparam int DEF_ID_BITS = 32;

  localparam logic [31:0] CAP_RESET = 32'd1048576;
  localparam int          CFG_ADDR_W = 3;

  // result kinds
  localparam logic [1:0] KIND_EVICT  = 2'd0;
  localparam logic [1:0] KIND_HIT    = 2'd1;
  localparam logic [1:0] KIND_INSERT = 2'd2;
  localparam logic [1:0] KIND_REJECT = 2'd3;

  // register index decoded from paddr[2]
  localparam logic REG_TOTAL_CAPACITY = 1'b0;

endpackage

// ===== design/slc_if.sv =====
// ----------------------------------------------------------------------------
// slc_in_if / slc_out_if
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
interface slc_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] resource_id;
  logic [31:0] resource_size;
  modport source (output valid, resource_id, resource_size, input ready);
  modport sink   (input valid, resource_id, resource_size, output ready);
endinterface

interface slc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] evicted_id;
  logic [31:0] evicted_size;
  logic [3:0]  slot;
  logic [31:0] allocated_total;
  logic        last;
  modport source (output valid, kind, evicted_id, evicted_size, slot, allocated_total, last,
                  input ready);
  modport sink   (input valid, kind, evicted_id, evicted_size, slot, allocated_total, last,
                  output ready);
endinterface

// ===== design/slc_mem.sv =====
// ----------------------------------------------------------------------------
// slc_mem
// Slot table RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module slc_mem #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 68
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== design/slc_cfg.sv =====
// ----------------------------------------------------------------------------
// slc_cfg
// APB register file holding the size budget.
// ----------------------------------------------------------------------------
module slc_cfg import slc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready,
  output logic [31:0]           capacity
);

  logic [31:0] cap_r;
  logic [31:0] cap_nxt;
  logic        sel_cap;

  assign sel_cap    = (cfg_paddr[2] == REG_TOTAL_CAPACITY);
  assign cfg_pready = 1'b1;
  assign cfg_prdata = sel_cap ? cap_r : 32'd0;
  assign capacity   = cap_r;

  always_comb begin
    cap_nxt = cap_r;
    if (cfg_psel && cfg_penable && cfg_pwrite && sel_cap) begin
      cap_nxt = cfg_pwdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else begin
      cap_r <= cap_nxt;
    end
  end

endmodule

// ===== design/size_budget_lru_cache.sv =====
// ----------------------------------------------------------------------------
// size_budget_lru_cache
// Size-budgeted LRU cache over a table of ENTRIES slots held in one RAM.
// ----------------------------------------------------------------------------
// One request is handled at a time. Every pass over the table reads one slot
// per cycle through the single RAM read port. A hit takes a lookup pass, a
// decision step and a rank-update pass, then emits its result. A rejection
// takes the lookup pass and the decision step. A miss takes the lookup, an
// eviction step per eviction plus a fresh LRU search pass for each eviction
// after the first, a rank-increment pass and an insert step. Results go out
// through an output register; the engine stalls only when it must emit
// while that register is still full. Valid bits live in flops and reset to
// empty, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module size_budget_lru_cache import slc_pkg::*; #(
  parameter int ENTRIES = DEF_ENTRIES,
  parameter int ID_BITS = DEF_ID_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  slc_in_if.sink                in_ch,
  slc_out_if.source             out_ch,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready
);

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int MEM_W = ID_BITS + 32 + IDX_W;

  typedef enum logic [8:0] {
    ST_IDLE    = 9'b000000001,
    ST_LOOKUP  = 9'b000000010,
    ST_DECIDE  = 9'b000000100,
    ST_HITBUMP = 9'b000001000,
    ST_HITOUT  = 9'b000010000,
    ST_EVCHK   = 9'b000100000,
    ST_FINDLRU = 9'b001000000,
    ST_BUMPALL = 9'b010000000,
    ST_INSERT  = 9'b100000000
  } state_t;

  logic [31:0] capacity;

  slc_cfg u_cfg (
    .clk, .rst_n, .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata,
    .cfg_prdata, .cfg_pready, .capacity
  );

  // table RAM: {id, size, rank}
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic [MEM_W-1:0] rd_data;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [MEM_W-1:0] wr_data;

  slc_mem #(.DEPTH(ENTRIES), .WIDTH(MEM_W)) u_mem (
    .clk, .rd_en, .rd_addr, .rd_data, .wr_en, .wr_addr, .wr_data
  );

  state_t               state_r, state_nxt;
  logic [ENTRIES-1:0]   valid_r, valid_nxt;
  logic [31:0]          alloc_r, alloc_nxt;
  logic [CNT_W-1:0]     used_r, used_nxt;
  logic [ID_BITS-1:0]   id_r, id_nxt;
  logic [31:0]          size_r, size_nxt;
  logic [CNT_W-1:0]     issue_r, issue_nxt;
  logic                 pipe_v_r, pipe_v_nxt;
  logic [IDX_W-1:0]     pipe_idx_r, pipe_idx_nxt;
  logic                 hit_r, hit_nxt;
  logic [IDX_W-1:0]     hit_slot_r, hit_slot_nxt;
  logic [IDX_W-1:0]     hit_rank_r, hit_rank_nxt;
  logic                 lru_ok_r, lru_ok_nxt;
  logic [IDX_W-1:0]     lru_slot_r, lru_slot_nxt;
  logic [ID_BITS-1:0]   lru_id_r, lru_id_nxt;
  logic [31:0]          lru_size_r, lru_size_nxt;
  logic                 free_ok_r, free_ok_nxt;
  logic [IDX_W-1:0]     free_slot_r, free_slot_nxt;

  logic                 ov_r, ov_nxt;
  logic [1:0]           o_kind_r, o_kind_nxt;
  logic [31:0]          o_eid_r, o_eid_nxt;
  logic [31:0]          o_esz_r, o_esz_nxt;
  logic [3:0]           o_slot_r, o_slot_nxt;
  logic [31:0]          o_alloc_r, o_alloc_nxt;
  logic                 o_last_r, o_last_nxt;

  logic                 out_free;
  logic                 sweeping;
  logic                 sweep_done;
  logic                 pv;
  logic [ID_BITS-1:0]   r_id;
  logic [31:0]          r_size;
  logic [IDX_W-1:0]     r_rank;
  logic                 is_lru;
  logic                 need_evict;
  logic [ID_BITS+31:0]  id_ext;
  logic [ID_BITS+31:0]  eid_ext;
  logic [IDX_W+3:0]     hit_slot_ext;
  logic [IDX_W+3:0]     free_slot_ext;

  assign out_free   = !ov_r || out_ch.ready;
  assign sweeping   = (state_r == ST_LOOKUP) || (state_r == ST_HITBUMP) ||
                      (state_r == ST_FINDLRU) || (state_r == ST_BUMPALL);
  assign sweep_done = pipe_v_r && (pipe_idx_r == IDX_W'(ENTRIES - 1));
  assign pv         = valid_r[pipe_idx_r];
  assign {r_id, r_size, r_rank} = rd_data;
  assign is_lru     = pv && (CNT_W'(r_rank) == (used_r - 1'b1));
  // over budget or table full
  assign need_evict = (({1'b0, alloc_r} + {1'b0, size_r}) > {1'b0, capacity}) ||
                      (used_r >= CNT_W'(ENTRIES));

  // ids are kept in their low ID_BITS bits; results carry the low 32
  assign id_ext        = {{ID_BITS{1'b0}}, in_ch.resource_id};
  assign eid_ext       = {32'd0, lru_id_r};
  assign hit_slot_ext  = {4'd0, hit_slot_r};
  assign free_slot_ext = {4'd0, free_slot_r};

  assign in_ch.ready = (state_r == ST_IDLE);

  assign out_ch.valid           = ov_r;
  assign out_ch.kind            = o_kind_r;
  assign out_ch.evicted_id      = o_eid_r;
  assign out_ch.evicted_size    = o_esz_r;
  assign out_ch.slot            = o_slot_r;
  assign out_ch.allocated_total = o_alloc_r;
  assign out_ch.last            = o_last_r;

  always_comb begin
    state_nxt     = state_r;
    valid_nxt     = valid_r;
    alloc_nxt     = alloc_r;
    used_nxt      = used_r;
    id_nxt        = id_r;
    size_nxt      = size_r;
    issue_nxt     = issue_r;
    pipe_idx_nxt  = pipe_idx_r;
    hit_nxt       = hit_r;
    hit_slot_nxt  = hit_slot_r;
    hit_rank_nxt  = hit_rank_r;
    lru_ok_nxt    = lru_ok_r;
    lru_slot_nxt  = lru_slot_r;
    lru_id_nxt    = lru_id_r;
    lru_size_nxt  = lru_size_r;
    free_ok_nxt   = free_ok_r;
    free_slot_nxt = free_slot_r;
    ov_nxt        = ov_r && !out_ch.ready;
    o_kind_nxt    = o_kind_r;
    o_eid_nxt     = o_eid_r;
    o_esz_nxt     = o_esz_r;
    o_slot_nxt    = o_slot_r;
    o_alloc_nxt   = o_alloc_r;
    o_last_nxt    = o_last_r;
    rd_en         = 1'b0;
    rd_addr       = issue_r[IDX_W-1:0];
    wr_en         = 1'b0;
    wr_addr       = pipe_idx_r;
    wr_data       = {r_id, r_size, r_rank + 1'b1};

    // sweep read issue: one slot per cycle
    if (sweeping && (issue_r < CNT_W'(ENTRIES))) begin
      rd_en     = 1'b1;
      issue_nxt = issue_r + 1'b1;
    end
    pipe_v_nxt = rd_en;
    if (rd_en) begin
      pipe_idx_nxt = rd_addr;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          id_nxt      = id_ext[ID_BITS-1:0];
          size_nxt    = in_ch.resource_size;
          hit_nxt     = 1'b0;
          lru_ok_nxt  = 1'b0;
          free_ok_nxt = 1'b0;
          issue_nxt   = '0;
          state_nxt   = ST_LOOKUP;
        end
      end
      ST_LOOKUP, ST_FINDLRU: begin
        if (pipe_v_r) begin
          if ((state_r == ST_LOOKUP) && pv && (r_id == id_r)) begin
            hit_nxt      = 1'b1;
            hit_slot_nxt = pipe_idx_r;
            hit_rank_nxt = r_rank;
          end
          if (is_lru) begin
            lru_slot_nxt = pipe_idx_r;
            lru_id_nxt   = r_id;
            lru_size_nxt = r_size;
          end
        end
        if (sweep_done) begin
          lru_ok_nxt = 1'b1;
          state_nxt  = (state_r == ST_LOOKUP) ? ST_DECIDE : ST_EVCHK;
        end
      end
      ST_DECIDE: begin
        if (hit_r) begin
          issue_nxt = '0;
          state_nxt = ST_HITBUMP;
        end else if (size_r > capacity) begin
          if (out_free) begin
            ov_nxt      = 1'b1;
            o_kind_nxt  = KIND_REJECT;
            o_eid_nxt   = '0;
            o_esz_nxt   = '0;
            o_slot_nxt  = '0;
            o_alloc_nxt = alloc_r;
            o_last_nxt  = 1'b1;
            state_nxt   = ST_IDLE;
          end
        end else begin
          state_nxt = ST_EVCHK;
        end
      end
      ST_HITBUMP: begin
        // younger entries age by one, the hit entry becomes most recent
        if (pipe_v_r && pv) begin
          if (pipe_idx_r == hit_slot_r) begin
            wr_en   = 1'b1;
            wr_data = {r_id, r_size, {IDX_W{1'b0}}};
          end else if (r_rank < hit_rank_r) begin
            wr_en = 1'b1;
          end
        end
        if (sweep_done) begin
          state_nxt = ST_HITOUT;
        end
      end
      ST_HITOUT: begin
        if (out_free) begin
          ov_nxt      = 1'b1;
          o_kind_nxt  = KIND_HIT;
          o_eid_nxt   = '0;
          o_esz_nxt   = '0;
          o_slot_nxt  = hit_slot_ext[3:0];
          o_alloc_nxt = alloc_r;
          o_last_nxt  = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      ST_EVCHK: begin
        if (need_evict && (used_r != '0)) begin
          if (lru_ok_r) begin
            if (out_free) begin
              valid_nxt[lru_slot_r] = 1'b0;
              alloc_nxt   = alloc_r - lru_size_r;
              used_nxt    = used_r - 1'b1;
              lru_ok_nxt  = 1'b0;
              ov_nxt      = 1'b1;
              o_kind_nxt  = KIND_EVICT;
              o_eid_nxt   = eid_ext[31:0];
              o_esz_nxt   = lru_size_r;
              o_slot_nxt  = '0;
              o_alloc_nxt = alloc_nxt;
              o_last_nxt  = 1'b0;
            end
          end else begin
            issue_nxt = '0;
            state_nxt = ST_FINDLRU;
          end
        end else begin
          issue_nxt = '0;
          state_nxt = ST_BUMPALL;
        end
      end
      ST_BUMPALL: begin
        // age every live entry, note the lowest free slot
        if (pipe_v_r) begin
          if (pv) begin
            wr_en = 1'b1;
          end else if (!free_ok_r) begin
            free_ok_nxt   = 1'b1;
            free_slot_nxt = pipe_idx_r;
          end
        end
        if (sweep_done) begin
          state_nxt = ST_INSERT;
        end
      end
      ST_INSERT: begin
        if (out_free) begin
          wr_en   = 1'b1;
          wr_addr = free_slot_r;
          wr_data = {id_r, size_r, {IDX_W{1'b0}}};
          valid_nxt[free_slot_r] = 1'b1;
          used_nxt    = used_r + 1'b1;
          alloc_nxt   = alloc_r + size_r;
          ov_nxt      = 1'b1;
          o_kind_nxt  = KIND_INSERT;
          o_eid_nxt   = '0;
          o_esz_nxt   = '0;
          o_slot_nxt  = free_slot_ext[3:0];
          o_alloc_nxt = alloc_nxt;
          o_last_nxt  = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      valid_r  <= '0;
      alloc_r  <= '0;
      used_r   <= '0;
      pipe_v_r <= 1'b0;
      ov_r     <= 1'b0;
      issue_r  <= '0;
      hit_r    <= 1'b0;
      lru_ok_r <= 1'b0;
      free_ok_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      valid_r  <= valid_nxt;
      alloc_r  <= alloc_nxt;
      used_r   <= used_nxt;
      pipe_v_r <= pipe_v_nxt;
      ov_r     <= ov_nxt;
      issue_r  <= issue_nxt;
      hit_r    <= hit_nxt;
      lru_ok_r <= lru_ok_nxt;
      free_ok_r <= free_ok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    id_r        <= id_nxt;
    size_r      <= size_nxt;
    pipe_idx_r  <= pipe_idx_nxt;
    hit_slot_r  <= hit_slot_nxt;
    hit_rank_r  <= hit_rank_nxt;
    lru_slot_r  <= lru_slot_nxt;
    lru_id_r    <= lru_id_nxt;
    lru_size_r  <= lru_size_nxt;
    free_slot_r <= free_slot_nxt;
    o_kind_r    <= o_kind_nxt;
    o_eid_r     <= o_eid_nxt;
    o_esz_r     <= o_esz_nxt;
    o_slot_r    <= o_slot_nxt;
    o_alloc_r   <= o_alloc_nxt;
    o_last_r    <= o_last_nxt;
  end

endmodule
